@@ hw/rtl/avwf_pkg.sv @@
`default_nettype none

package avwf_pkg;

  // fixed field widths
  localparam int unsigned SCALE_W     = 32;
  localparam int unsigned ANGLE_OUT_W = 21;
  localparam int unsigned VEL_OUT_W   = 31;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // output fraction bits (signed Q5.16 angle, signed Q15.16 velocity)
  localparam int unsigned FRAC_BITS = 16;

  // register reset values
  localparam int          UPPER_LIMIT_RST    = 1020;
  localparam int          LOWER_LIMIT_RST    = 10;
  localparam logic [SCALE_W-1:0] POS_SCALE_RST = 32'd810880;
  localparam logic [SCALE_W-1:0] VEL_SCALE_RST = 32'd405439834;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_LIMIT    = 2'd0,
    CFG_LOWER_LIMIT    = 2'd1,
    CFG_POSITION_SCALE = 2'd2,
    CFG_VELOCITY_SCALE = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ hw/rtl/avwf_ram.sv @@
`default_nettype none

module avwf_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/angle_velocity_window_filter.sv @@
// angle and velocity window filter
//
// input channel: one signed angle sample per item (in_valid_i / in_ready_o).
// output channel: one result per input item (out_valid_o / out_ready_i) with
// the filtered angle, the filtered (or held) velocity and the clamp flag.
// configuration: cfg_we_i writes cfg_data_i into the register at cfg_index_i
// in the same edge; write only while no item is in flight.
// path: an accepted item is held in the input register, then one pass of
// window update and scaling writes its result into the result register.
// throughput: one item per cycle while results are taken, set by the single
// window-update plus multiply pass between the two registers.
// the oldest window entries are prefetched from two small RAMs one item
// ahead, so the slot counters drive the RAM read ports.
// reset: fill flags, sums, slots, previous sample, held velocity and clamp flag
// clear; limits and scales return to their defaults. window RAMs are not
// cleared, a fill flag per window masks entries not yet written as zero.
// receiver stall: the result register holds; one more item may be taken
// into the input register, after which in_ready_o drops until the result
// is taken.

`default_nettype none

module angle_velocity_window_filter
  import avwf_pkg::*;
#(
  parameter int unsigned WINDOW_LEN  = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] angle_sample_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [ANGLE_OUT_W-1:0]      angle_out_o,
  output logic signed [VEL_OUT_W-1:0]        velocity_out_o,
  output logic                               clamped_o,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned SLOT_W   = $clog2(WINDOW_LEN);
  localparam int unsigned A_SUM_W  = SAMPLE_BITS + SLOT_W;
  localparam int unsigned D_W      = SAMPLE_BITS + 1;
  localparam int unsigned D_SUM_W  = D_W + SLOT_W;
  // sum times zero-extended unsigned scale
  localparam int unsigned A_PROD_W = A_SUM_W + SCALE_W + 1;
  localparam int unsigned D_PROD_W = D_SUM_W + SCALE_W + 1;
  localparam int unsigned A_SH_W   = A_PROD_W - FRAC_BITS;
  localparam int unsigned D_SH_W   = D_PROD_W - FRAC_BITS;
  localparam int unsigned A_EXT_W  = ((A_SH_W > ANGLE_OUT_W) ? A_SH_W : ANGLE_OUT_W) + 1;
  localparam int unsigned D_EXT_W  = ((D_SH_W > VEL_OUT_W) ? D_SH_W : VEL_OUT_W) + 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  localparam logic signed [ANGLE_OUT_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_OUT_W-1){1'b1}}};
  localparam logic signed [ANGLE_OUT_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_OUT_W-1){1'b0}}};
  localparam logic signed [VEL_OUT_W-1:0]   VEL_MAX   = {1'b0, {(VEL_OUT_W-1){1'b1}}};
  localparam logic signed [VEL_OUT_W-1:0]   VEL_MIN   = {1'b1, {(VEL_OUT_W-1){1'b0}}};

  // configuration registers
  logic signed [SAMPLE_BITS-1:0] upper_q;
  logic signed [SAMPLE_BITS-1:0] lower_q;
  logic [SCALE_W-1:0]            pos_scale_q;
  logic [SCALE_W-1:0]            vel_scale_q;

  // handshake / pipeline control
  logic                          in_valid_q, in_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_valid_q, out_valid_d;
  logic                          advance;
  logic                          fire;
  logic                          in_take;

  // filter state
  logic signed [A_SUM_W-1:0]     a_sum_q, a_sum_d;
  logic [SLOT_W-1:0]             a_slot_q, a_slot_next;
  logic                          a_filled_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [D_SUM_W-1:0]     d_sum_q, d_sum_d;
  logic [SLOT_W-1:0]             d_slot_q, d_slot_next;
  logic                          d_filled_q;
  logic signed [VEL_OUT_W-1:0]   held_q, held_d;
  logic                          clamp_q, clamp_d;

  // result register
  logic signed [ANGLE_OUT_W-1:0] angle_out_q, angle_d;
  logic signed [VEL_OUT_W-1:0]   vel_out_q;
  logic                          clamped_q;

  // window RAM ports
  logic [SAMPLE_BITS-1:0]        a_rdata;
  logic [D_W-1:0]                d_rdata;
  logic                          d_upd;
  logic                          d_we;

  // datapath
  logic signed [SAMPLE_BITS-1:0] a_old;
  logic signed [D_W-1:0]         diff;
  logic signed [D_W-1:0]         d_old;
  logic signed [A_PROD_W-1:0]    a_prod;
  logic signed [D_PROD_W-1:0]    d_prod;
  logic signed [A_SH_W-1:0]      a_sh;
  logic signed [D_SH_W-1:0]      d_sh;
  logic signed [A_EXT_W-1:0]     a_ext;
  logic signed [D_EXT_W-1:0]     d_ext;
  logic signed [VEL_OUT_W-1:0]   vel_sat;
  logic                          in_band;
  logic                          out_band;
  logic                          release_ok;

  // ---------------------------------------------------------------------------
  // handshake: input register feeds one compute pass into the result register
  // ---------------------------------------------------------------------------
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // window RAMs, read port prefetches the entry at the next slot
  // ---------------------------------------------------------------------------
  assign a_slot_next = (a_slot_q == LAST_SLOT) ? '0 : a_slot_q + SLOT_W'(1);
  assign d_slot_next = (d_slot_q == LAST_SLOT) ? '0 : d_slot_q + SLOT_W'(1);
  assign d_we        = fire && d_upd;

  avwf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_angle_ram (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (a_slot_q),
    .wdata_i (sample_q),
    .re_i    (fire),
    .raddr_i (a_slot_next),
    .rdata_o (a_rdata)
  );

  avwf_ram #(
    .WIDTH (D_W),
    .DEPTH (WINDOW_LEN)
  ) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_slot_q),
    .wdata_i (diff),
    .re_i    (d_we),
    .raddr_i (d_slot_next),
    .rdata_o (d_rdata)
  );

  // ---------------------------------------------------------------------------
  // compute pass
  // ---------------------------------------------------------------------------
  always_comb begin
    // oldest entry reads as zero until the window has wrapped once
    a_old = a_filled_q ? $signed(a_rdata) : '0;
    d_old = d_filled_q ? $signed(d_rdata) : '0;

    diff = D_W'(sample_q) - D_W'(prev_q);

    // position path: window always advances
    a_sum_d = a_sum_q + A_SUM_W'(sample_q) - A_SUM_W'(a_old);
    a_prod  = a_sum_d * $signed({1'b0, pos_scale_q});
    a_sh    = A_SH_W'(a_prod >>> FRAC_BITS);
    a_ext   = A_EXT_W'(a_sh);
    if (a_ext > A_EXT_W'(ANGLE_MAX)) begin
      angle_d = ANGLE_MAX;
    end else if (a_ext < A_EXT_W'(ANGLE_MIN)) begin
      angle_d = ANGLE_MIN;
    end else begin
      angle_d = ANGLE_OUT_W'(a_ext);
    end

    // velocity path: difference window candidate
    d_sum_d = d_sum_q + D_SUM_W'(diff) - D_SUM_W'(d_old);
    d_prod  = d_sum_d * $signed({1'b0, vel_scale_q});
    d_sh    = D_SH_W'(d_prod >>> FRAC_BITS);
    d_ext   = D_EXT_W'(d_sh);
    if (d_ext > D_EXT_W'(VEL_MAX)) begin
      vel_sat = VEL_MAX;
    end else if (d_ext < D_EXT_W'(VEL_MIN)) begin
      vel_sat = VEL_MIN;
    end else begin
      vel_sat = VEL_OUT_W'(d_ext);
    end

    // clamp control
    in_band  = (sample_q < upper_q) && (sample_q > lower_q);
    out_band = (sample_q > upper_q) || (sample_q < lower_q);
    // release: difference and held output agree in sign, sample back inside
    release_ok = (!diff[D_W-1] && !held_q[VEL_OUT_W-1] && (sample_q < upper_q))
              || ((diff[D_W-1] || (diff == '0))
                  && (held_q[VEL_OUT_W-1] || (held_q == '0))
                  && (sample_q > lower_q));

    d_upd   = in_band && !clamp_q;
    held_d  = held_q;
    clamp_d = clamp_q;
    if (d_upd) begin
      held_d = vel_sat;
    end else if (out_band && !clamp_q) begin
      clamp_d = 1'b1;
    end else if (release_ok) begin
      clamp_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // control and filter state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_sum_q     <= '0;
      a_slot_q    <= '0;
      a_filled_q  <= 1'b0;
      prev_q      <= '0;
      d_sum_q     <= '0;
      d_slot_q    <= '0;
      d_filled_q  <= 1'b0;
      held_q      <= '0;
      clamp_q     <= 1'b0;
      upper_q     <= SAMPLE_BITS'(UPPER_LIMIT_RST);
      lower_q     <= SAMPLE_BITS'(LOWER_LIMIT_RST);
      pos_scale_q <= POS_SCALE_RST;
      vel_scale_q <= VEL_SCALE_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;

      if (fire) begin
        a_sum_q  <= a_sum_d;
        a_slot_q <= a_slot_next;
        if (a_slot_q == LAST_SLOT) begin
          a_filled_q <= 1'b1;
        end
        prev_q  <= sample_q;
        held_q  <= held_d;
        clamp_q <= clamp_d;
        if (d_upd) begin
          d_sum_q  <= d_sum_d;
          d_slot_q <= d_slot_next;
          if (d_slot_q == LAST_SLOT) begin
            d_filled_q <= 1'b1;
          end
        end
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_UPPER_LIMIT:    upper_q     <= cfg_data_i[SAMPLE_BITS-1:0];
          CFG_LOWER_LIMIT:    lower_q     <= cfg_data_i[SAMPLE_BITS-1:0];
          CFG_POSITION_SCALE: pos_scale_q <= cfg_data_i[SCALE_W-1:0];
          CFG_VELOCITY_SCALE: vel_scale_q <= cfg_data_i[SCALE_W-1:0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= angle_sample_i;
    end
    if (fire) begin
      angle_out_q <= angle_d;
      vel_out_q   <= held_d;
      clamped_q   <= clamp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign angle_out_o    = angle_out_q;
  assign velocity_out_o = vel_out_q;
  assign clamped_o      = clamped_q;

endmodule

`default_nettype wire

@@ test/tb_angle_velocity_window_filter.sv @@
`timescale 1ns / 1ps

module tb_angle_velocity_window_filter;
  import avwf_pkg::*;

  localparam int SAMPLE_W       = 12;
  localparam int WIN_LEN        = 32;
  // quiet cycles allowed before the run is declared hung; the worst legal
  // quiet stretch is a sender gap overlapping a receiver stall
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [ANGLE_OUT_W-1:0] angle;
    logic signed [VEL_OUT_W-1:0]   velocity;
    logic                          clamped;
  } filt_result_t;

  // dut signals; the driven inputs are known from time zero
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  sample_t                       angle_sample_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic signed [ANGLE_OUT_W-1:0] angle_out_o;
  logic signed [VEL_OUT_W-1:0]   velocity_out_o;
  logic                          clamped_o;
  logic                          cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]         cfg_data_i     = '0;

  angle_velocity_window_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .angle_sample_i (angle_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angle_out_o    (angle_out_o),
    .velocity_out_o (velocity_out_o),
    .clamped_o      (clamped_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // filter predictor: its own copy of the windows, sums, clamp state and
  // registers, stepped once per accepted item
  // ---------------------------------------------------------------------
  sample_t                     ang_hist [WIN_LEN];
  int                          ang_total;
  int                          ang_pos;
  sample_t                     last_ang;
  int                          dif_hist [WIN_LEN];
  int                          dif_total;
  int                          dif_pos;
  logic signed [VEL_OUT_W-1:0] vel_hold;
  logic                        clamp_st;
  sample_t                     upper_lim;
  sample_t                     lower_lim;
  logic [CFG_DATA_W-1:0]       pos_gain;
  logic [CFG_DATA_W-1:0]       vel_gain;

  // filtered results still owed by the block, oldest first
  filt_result_t                filt_q [$];

  int                          mismatch_count = 0;
  int                          quiet_cycles   = 0;
  int                          stall_left     = 0;
  bit                          tx_idle_en     = 1'b0;
  bit                          rx_idle_en     = 1'b0;

  function automatic void reset_filter_state();
    foreach (ang_hist[k]) ang_hist[k] = '0;
    foreach (dif_hist[k]) dif_hist[k] = 0;
    ang_total = 0;
    ang_pos   = 0;
    last_ang  = '0;
    dif_total = 0;
    dif_pos   = 0;
    vel_hold  = '0;
    clamp_st  = 1'b0;
    upper_lim = sample_t'(UPPER_LIMIT_RST);
    lower_lim = sample_t'(LOWER_LIMIT_RST);
    pos_gain  = POS_SCALE_RST;
    vel_gain  = VEL_SCALE_RST;
  endfunction

  // sum times unsigned Q0.32 gain, floor shift down to Q.16, saturated: Q5.16 angle, Q15.16 velocity
  function automatic longint scaled_q16(input int acc, input logic [CFG_DATA_W-1:0] gain,
                                        input int bits);
    longint prod;
    longint hi;
    prod = longint'(acc) * longint'(gain);
    prod = prod >>> FRAC_BITS;
    hi   = (longint'(1) <<< (bits - 1)) - 1;
    if (prod > hi) return hi;
    if (prod < -hi - 1) return -hi - 1;
    return prod;
  endfunction

  function automatic filt_result_t filter_step(input sample_t s);
    int           d;
    int           up;
    int           lo;
    longint       ang;
    filt_result_t r;
    up = upper_lim;
    lo = lower_lim;
    d  = s - last_ang;

    // position window always moves
    ang_total = ang_total + s - ang_hist[ang_pos];
    ang_hist[ang_pos] = s;
    ang_pos = (ang_pos + 1) % WIN_LEN;
    ang = scaled_q16(ang_total, pos_gain, ANGLE_OUT_W);

    if (s < up && s > lo && !clamp_st) begin
      // inside the band: difference window moves, velocity recomputed
      dif_total = dif_total + d - dif_hist[dif_pos];
      dif_hist[dif_pos] = d;
      dif_pos = (dif_pos + 1) % WIN_LEN;
      vel_hold = VEL_OUT_W'(scaled_q16(dif_total, vel_gain, VEL_OUT_W));
    end else if ((s > up || s < lo) && !clamp_st) begin
      clamp_st = 1'b1;
    end else begin
      // release once motion and held velocity agree and we are back inside
      if (d >= 0 && vel_hold >= 0 && s < up) clamp_st = 1'b0;
      else if (d <= 0 && vel_hold <= 0 && s > lo) clamp_st = 1'b0;
    end
    last_ang = s;

    r.angle    = ang[ANGLE_OUT_W-1:0];
    r.velocity = vel_hold;
    r.clamped  = clamp_st;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  // drive one item from a falling edge and hold it until the block takes it,
  // with an optional idle burst before it
  task automatic send_angle(input sample_t a);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    angle_sample_i <= a;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    filt_q.push_back(filter_step(a));
  endtask

  // stop sending and let every owed result come out, plus pipeline slack
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_UPPER_LIMIT:    upper_lim = data[SAMPLE_W-1:0];
      CFG_LOWER_LIMIT:    lower_lim = data[SAMPLE_W-1:0];
      CFG_POSITION_SCALE: pos_gain  = data;
      CFG_VELOCITY_SCALE: vel_gain  = data;
      default: ;
    endcase
  endtask

  // all four registers back to back; limit writes carry junk above bit 11
  task automatic set_config(input sample_t up, input sample_t lo,
                            input logic [CFG_DATA_W-1:0] pg,
                            input logic [CFG_DATA_W-1:0] vg);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    write_reg(CFG_UPPER_LIMIT, {junk[CFG_DATA_W-1:SAMPLE_W], up});
    junk = $urandom();
    write_reg(CFG_LOWER_LIMIT, {junk[CFG_DATA_W-1:SAMPLE_W], lo});
    write_reg(CFG_POSITION_SCALE, pg);
    write_reg(CFG_VELOCITY_SCALE, vg);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random well-ordered band, lower strictly below upper
  task automatic pick_band(output sample_t up, output sample_t lo);
    int a;
    int b;
    a = int'($urandom_range(0, 4095)) - 2048;
    do begin
      b = int'($urandom_range(0, 4095)) - 2048;
    end while (b == a);
    up = sample_t'((a > b) ? a : b);
    lo = sample_t'((a > b) ? b : a);
  endtask

  // mostly shaft-like trajectories that sweep through the band and wrap,
  // some items pinned around the limits, some pure noise
  task automatic run_random_phase(input int n_items, input bit tx_idle, input bit rx_idle);
    int pos;
    int step;
    int seg;
    int kind;
    int pick;
    int done;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    pos  = int'($urandom_range(0, 4095)) - 2048;
    step = int'($urandom_range(0, 40)) - 20;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 19);
      seg  = $urandom_range(8, 60);
      for (int k = 0; k < seg && done < n_items; k++) begin
        if (kind < 14) begin
          if ($urandom_range(0, 15) == 0) step = int'($urandom_range(0, 120)) - 60;
          pos = pos + step + int'($urandom_range(0, 6)) - 3;
          if (pos > 2047) pos -= 4096;
          else if (pos < -2048) pos += 4096;
          send_angle(sample_t'(pos));
        end else if (kind < 17) begin
          // one below, at, or one above either limit
          pick = $urandom_range(0, 5);
          send_angle(sample_t'(((pick < 3) ? int'(upper_lim) : int'(lower_lim))
                               + (pick % 3) - 1));
        end else begin
          send_angle(sample_t'($urandom()));
        end
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset band 10..1020: entry below and above, samples exactly on a limit,
  // release from both sides, field extremes
  task automatic test_clamp_edges();
    sample_t seq [$] = '{0, 10, 500, 1020, 1021, 2047, -2048, 1000, 800, 9, 10,
                         1019, 1020, -1};
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (seq[k]) send_angle(seq[k]);
  endtask

  // full-scale gains force the angle output into saturation, then zero gains
  task automatic test_saturation();
    sample_t sat_seq [$] = '{2047, -2048, -2048, 2046};
    sample_t zero_seq [$] = '{1234, -5};
    wait_results_drained();
    set_config(sample_t'(2047), sample_t'(-2048), '1, '1);
    foreach (sat_seq[k]) send_angle(sat_seq[k]);
    wait_results_drained();
    set_config(sample_t'(UPPER_LIMIT_RST), sample_t'(LOWER_LIMIT_RST), '0, '0);
    foreach (zero_seq[k]) send_angle(zero_seq[k]);
  endtask

  // lower above upper: the difference window can never move
  task automatic test_crossed_limits();
    sample_t seq [$] = '{0, 200, -200, 100, -100};
    wait_results_drained();
    set_config(sample_t'(-100), sample_t'(100), POS_SCALE_RST, VEL_SCALE_RST);
    foreach (seq[k]) send_angle(seq[k]);
  endtask

  // phases of random traffic, each under its own register setting
  task automatic test_random_tracking();
    sample_t up;
    sample_t lo;
    sample_t tmp;
    wait_results_drained();
    set_config(sample_t'(UPPER_LIMIT_RST), sample_t'(LOWER_LIMIT_RST),
               POS_SCALE_RST, VEL_SCALE_RST);
    run_random_phase(200, 1'b1, 1'b1);

    wait_results_drained();
    pick_band(up, lo);
    set_config(up, lo, $urandom(), $urandom());
    run_random_phase(200, 1'b1, 1'b1);

    // widest band with maximum gains
    wait_results_drained();
    set_config(sample_t'(2047), sample_t'(-2048), '1, '1);
    run_random_phase(200, 1'b1, 1'b0);

    wait_results_drained();
    pick_band(up, lo);
    set_config(up, lo, '0, '0);
    run_random_phase(150, 1'b0, 1'b1);

    // crossed band with moderate gains
    wait_results_drained();
    pick_band(up, lo);
    tmp = up;
    up  = lo;
    lo  = tmp;
    set_config(up, lo, $urandom_range(0, 1 << 22), VEL_SCALE_RST << 1);
    run_random_phase(150, 1'b1, 1'b1);

    wait_results_drained();
    pick_band(up, lo);
    set_config(up, lo, POS_SCALE_RST, '1);
    run_random_phase(200, 1'b1, 1'b1);

    // degenerate band, both limits equal
    wait_results_drained();
    up = sample_t'($urandom());
    set_config(up, up, $urandom(), $urandom_range(0, 1 << 24));
    run_random_phase(100, 1'b1, 1'b1);
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_streaming_no_idle();
    sample_t up;
    sample_t lo;
    wait_results_drained();
    pick_band(up, lo);
    set_config(up, lo, $urandom_range(0, 1 << 23), $urandom());
    run_random_phase(300, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // receiver side: random stall bursts, driven from the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endfunction

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk_i) begin
    filt_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (filt_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result angle %0d velocity %0d clamped %0b",
                                angle_out_o, velocity_out_o, clamped_o));
      end else begin
        want = filt_q.pop_front();
        if (angle_out_o !== want.angle)
          note_mismatch($sformatf("angle_out expected %0d got %0d", want.angle, angle_out_o));
        if (velocity_out_o !== want.velocity)
          note_mismatch($sformatf("velocity_out expected %0d got %0d",
                                  want.velocity, velocity_out_o));
        if (clamped_o !== want.clamped)
          note_mismatch($sformatf("clamped expected %0b got %0b", want.clamped, clamped_o));
      end
    end
  end

  // watchdog: counts cycles in which neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    reset_filter_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_clamp_edges();
    test_saturation();
    test_crossed_limits();
    test_random_tracking();
    test_streaming_no_idle();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
